### sv/cvss_pkg.sv
// ----------------------------------------------------------------------------
// cvss_pkg: shared types and codes for the color vote sort sequencer
// Configuration record, result record, phase encoding and field codes.
// ----------------------------------------------------------------------------
package cvss_pkg;

  localparam int CFG_WIDTH   = 16;
  localparam int INDEX_WIDTH = 2;

  // Configuration register indexes
  localparam logic [INDEX_WIDTH-1:0] REG_TRAVEL_DELAY  = 2'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_SAMPLE_WINDOW = 2'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_PAGE_HOLD     = 2'd2;

  localparam logic [CFG_WIDTH-1:0] TRAVEL_DELAY_RST  = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] SAMPLE_WINDOW_RST = 16'd500;
  localparam logic [CFG_WIDTH-1:0] PAGE_HOLD_RST     = 16'd1000;

  // Color sensor verdicts
  localparam logic [1:0] COLOR_RED   = 2'd1;
  localparam logic [1:0] COLOR_GREEN = 2'd2;

  // Machine modes
  localparam logic [1:0] MODE_ON      = 2'd0;
  localparam logic [1:0] MODE_ERRATIC = 2'd1;

  // Display pages
  localparam logic [1:0] PAGE_IDLE  = 2'd0;
  localparam logic [1:0] PAGE_GREEN = 2'd1;
  localparam logic [1:0] PAGE_RED   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_TRAVEL = 3'b010,
    PH_SAMPLE = 3'b100
  } cvss_phase_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] travel_delay_ms;
    logic [CFG_WIDTH-1:0] sample_window_ms;
    logic [CFG_WIDTH-1:0] page_hold_ms;
  } cvss_cfg_t;

  typedef struct packed {
    logic       tower_lamp;
    logic [1:0] page_number;
    logic       page_write;
  } cvss_result_t;

endpackage

### sv/cvss_cfg.sv
// ----------------------------------------------------------------------------
// cvss_cfg: configuration register file
// Holds the three timing registers; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module cvss_cfg
  import cvss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  output cvss_cfg_t              cfg
);

  cvss_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRAVEL_DELAY:  cfg_nxt.travel_delay_ms  = cfg_data;
        REG_SAMPLE_WINDOW: cfg_nxt.sample_window_ms = cfg_data;
        REG_PAGE_HOLD:     cfg_nxt.page_hold_ms     = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.travel_delay_ms  <= TRAVEL_DELAY_RST;
      cfg_r.sample_window_ms <= SAMPLE_WINDOW_RST;
      cfg_r.page_hold_ms     <= PAGE_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/cvss_core.sv
// ----------------------------------------------------------------------------
// cvss_core: sequencer state and per-poll step logic
// Detection, travel wait, vote window, page hold and lamp update for one poll.
// ----------------------------------------------------------------------------
module cvss_core
  import cvss_pkg::*;
#(
  parameter int VOTE_WIDTH = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [TIME_WIDTH-1:0] now_ms,
  input  logic                  object_seen,
  input  logic [1:0]            color_class,
  input  logic [1:0]            machine_mode,
  input  cvss_cfg_t             cfg,
  output cvss_result_t          result
);

  cvss_phase_t           phase_r, phase_nxt;
  logic                  page_shown_r, page_shown_nxt;
  logic [TIME_WIDTH-1:0] detect_time_r, detect_time_nxt;
  logic [TIME_WIDTH-1:0] window_time_r, window_time_nxt;
  logic [TIME_WIDTH-1:0] page_time_r, page_time_nxt;
  logic [VOTE_WIDTH-1:0] red_votes_r, red_votes_nxt;
  logic [VOTE_WIDTH-1:0] green_votes_r, green_votes_nxt;
  logic                  lamp_level_r, lamp_level_nxt;

  logic [TIME_WIDTH-1:0] el_detect, el_window, el_page;
  logic [TIME_WIDTH-1:0] travel_lim, window_lim, hold_lim;
  logic                  detect, travel_done, result_set;
  logic                  page_write;
  logic [1:0]            page_number;

  // wrapping differences
  assign el_detect  = now_ms - detect_time_r;
  assign el_window  = now_ms - window_time_r;
  assign el_page    = now_ms - page_time_r;
  assign travel_lim = TIME_WIDTH'(cfg.travel_delay_ms);
  assign window_lim = TIME_WIDTH'(cfg.sample_window_ms);
  assign hold_lim   = TIME_WIDTH'(cfg.page_hold_ms);

  assign detect = object_seen && (phase_r == PH_IDLE) && !page_shown_r;
  // on the detection poll the elapsed time is zero
  assign travel_done = detect ? (cfg.travel_delay_ms == '0) : (el_detect >= travel_lim);

  always_comb begin
    phase_nxt       = phase_r;
    page_shown_nxt  = page_shown_r;
    detect_time_nxt = detect_time_r;
    window_time_nxt = window_time_r;
    page_time_nxt   = page_time_r;
    red_votes_nxt   = red_votes_r;
    green_votes_nxt = green_votes_r;
    lamp_level_nxt  = lamp_level_r;
    page_write      = 1'b0;
    page_number     = PAGE_IDLE;
    result_set      = 1'b0;

    if (detect) begin
      detect_time_nxt = now_ms;
      red_votes_nxt   = '0;
      green_votes_nxt = '0;
      phase_nxt       = PH_TRAVEL;
      if (travel_done) begin
        phase_nxt       = PH_SAMPLE;
        window_time_nxt = now_ms;
      end
    end else begin
      unique case (phase_r)
        PH_TRAVEL: begin
          if (travel_done) begin
            phase_nxt       = PH_SAMPLE;
            window_time_nxt = now_ms;
          end
        end
        PH_SAMPLE: begin
          if (el_window <= window_lim) begin
            if (color_class == COLOR_RED) begin
              if (!(&red_votes_r)) red_votes_nxt = red_votes_r + VOTE_WIDTH'(1);
            end else if (color_class == COLOR_GREEN) begin
              if (!(&green_votes_r)) green_votes_nxt = green_votes_r + VOTE_WIDTH'(1);
            end
          end else begin
            result_set     = 1'b1;
            page_write     = 1'b1;
            page_number    = (red_votes_r > green_votes_r) ? PAGE_RED : PAGE_GREEN;
            page_shown_nxt = 1'b1;
            page_time_nxt  = now_ms;
            phase_nxt      = PH_IDLE;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    // hold expiry; a page set on this poll has zero elapsed time
    if (result_set ? (cfg.page_hold_ms == '0) : (page_shown_r && (el_page >= hold_lim))) begin
      page_write     = 1'b1;
      page_number    = PAGE_IDLE;
      page_shown_nxt = 1'b0;
    end

    if (machine_mode == MODE_ON) begin
      lamp_level_nxt = 1'b0;
    end else if (machine_mode == MODE_ERRATIC) begin
      lamp_level_nxt = 1'b1;
    end
  end

  assign result.page_write  = page_write;
  assign result.page_number = page_number;
  assign result.tower_lamp  = lamp_level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      page_shown_r  <= 1'b0;
      detect_time_r <= '0;
      window_time_r <= '0;
      page_time_r   <= '0;
      red_votes_r   <= '0;
      green_votes_r <= '0;
      lamp_level_r  <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      page_shown_r  <= page_shown_nxt;
      detect_time_r <= detect_time_nxt;
      window_time_r <= window_time_nxt;
      page_time_r   <= page_time_nxt;
      red_votes_r   <= red_votes_nxt;
      green_votes_r <= green_votes_nxt;
      lamp_level_r  <= lamp_level_nxt;
    end
  end

endmodule

### sv/color_vote_sort_sequencer.sv
// ----------------------------------------------------------------------------
// color_vote_sort_sequencer: color vote sorting sequencer
// Input register, combinational poll step, output register.
// ----------------------------------------------------------------------------
// Path: an accepted request waits in the input register; its result is registered when the step runs.
// Throughput: one request per cycle while the output is not stalled; the step
// logic between the input and output registers updates all sequencer state.
// Reset (rst_n low, synchronous): sequencer idle, votes and times zero, lamp
// low, timing registers back to 1000 / 500 / 1000 ms, both registers empty.
module color_vote_sort_sequencer
  import cvss_pkg::*;
#(
  parameter int VOTE_WIDTH = 16,
  parameter int TIME_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // in_tdata: now_ms, object_seen, color_class, machine_mode, zero fill
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [((TIME_WIDTH+12)/8)*8-1:0] in_tdata,
  // out_tdata: page_write, page_number, tower_lamp, zero fill
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [7:0]               out_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [INDEX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]     cfg_data
);

  cvss_cfg_t             cfg;
  cvss_result_t          result;

  logic                  in_valid_r, in_valid_nxt;
  logic [TIME_WIDTH-1:0] now_r;
  logic                  seen_r;
  logic [1:0]            color_r, mode_r;
  logic                  out_valid_r, out_valid_nxt;
  cvss_result_t          out_r;
  logic                  in_take, step;

  cvss_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvss_core #(
    .VOTE_WIDTH (VOTE_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .now_ms       (now_r),
    .object_seen  (seen_r),
    .color_class  (color_r),
    .machine_mode (mode_r),
    .cfg          (cfg),
    .result       (result)
  );

  // advance the held request whenever the output register is free or draining
  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      now_r   <= in_tdata[TIME_WIDTH-1:0];
      seen_r  <= in_tdata[TIME_WIDTH];
      color_r <= in_tdata[TIME_WIDTH+2:TIME_WIDTH+1];
      mode_r  <= in_tdata[TIME_WIDTH+4:TIME_WIDTH+3];
    end
    if (step) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r};

endmodule
